[hw/rtl/canrxf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// canrxf_pkg: shared types and constants of the CAN receive frame FIFO
// Command and status codes, field widths, slot layout and the byte masking
// used when a frame is stored.
// ----------------------------------------------------------------------------
package canrxf_pkg;

   localparam int RING_DEPTH_DEFAULT = 16;

   localparam int ID_W      = 11;
   localparam int LEN_W     = 4;
   localparam int PAYLOAD_W = 64;
   localparam int TIME_W    = 32;
   localparam int PERIOD_W  = 16;
   localparam int SEQ_W     = 8;

   localparam int REQ_TDATA_W = 112;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [LEN_W-1:0]    MAX_DLC        = 4'd8;
   localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 16'd2000;
   localparam logic [ID_W-1:0]     BEAT_ID        = 11'h7FE;
   localparam logic [7:0]          BEAT_BYTE0     = 8'hA5;
   localparam logic [7:0]          BEAT_BYTE1     = 8'h5A;

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_TICK = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_FULL     = 3'd1,
      ST_EXTENDED = 3'd2,
      ST_POPPED   = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_BEAT     = 3'd5,
      ST_NO_BEAT  = 3'd6
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COMMAND_ID = 1'b0,
      CSR_PERIOD     = 1'b1
   } csr_index_type;

   // Work left for the second stage of a request.
   typedef enum logic [1:0] {
      OP_DONE = 2'd0,
      OP_POP  = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [LEN_W-1:0]     length;
      logic [ID_W-1:0]      id;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   function automatic logic [PAYLOAD_W-1:0] keep_bytes(input logic [PAYLOAD_W-1:0] data,
                                                       input logic [LEN_W-1:0] len);
      logic [PAYLOAD_W-1:0] result;
      result = '0;
      for (int i = 0; i < 8; i++) begin
         if (len > LEN_W'(i)) begin
            result[8*i +: 8] = data[8*i +: 8];
         end
      end
      return result;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/canrxf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// canrxf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data that holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module canrxf_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AddrWidth-1:0]  wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AddrWidth-1:0]  rd_addr,
   output logic      [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/can_rx_frame_fifo_with_heartbeat.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// can_rx_frame_fifo_with_heartbeat: CAN receive frame FIFO with heartbeat
// Buffers standard-ID frames in a ring, returns them on pop, and answers
// time ticks with a heartbeat frame when the period is up and not silenced.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result side is ready and
// returns exactly one result for each from its result register. The first
// stage updates the ring pointers and reads or writes the slot RAM, whose
// read data is registered; the second stage forms the result, keeps the
// quiet flag and runs the heartbeat timer.
// The ring holds RING_DEPTH-1 frames. Slot storage is not cleared by reset
// and needs no clearing pass, so requests are taken right after reset.
module can_rx_frame_fifo_with_heartbeat #(
   parameter int RING_DEPTH = canrxf_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // frame_id, frame_length, frame_payload, now_ms, zero fill
   input  wire logic [canrxf_pkg::REQ_TDATA_W-1:0] req_tdata,
   // cmd, frame_extended
   input  wire logic [canrxf_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // out_id, out_length, out_payload, quiet
   output logic      [canrxf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status
   output logic      [canrxf_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [canrxf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [canrxf_pkg::CSR_DATA_W-1:0]  csr_data
);

   import canrxf_pkg::*;

   localparam int PtrWidth = $clog2(RING_DEPTH);
   localparam logic [PtrWidth-1:0] LastSlot = PtrWidth'(RING_DEPTH - 1);

   // Request fields
   cmd_type              req_cmd;
   logic                 req_extended;
   logic [ID_W-1:0]      req_id;
   logic [LEN_W-1:0]     req_length;
   logic [PAYLOAD_W-1:0] req_payload;
   logic [TIME_W-1:0]    req_now;
   logic [LEN_W-1:0]     clamped_length;

   // Configuration
   logic [ID_W-1:0]     command_id_ff;
   logic [PERIOD_W-1:0] period_ff;

   // Ring pointers and slot RAM
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in, rd_next;
   logic                ram_wr_en, ram_rd_en;
   slot_type            ram_wr_data;
   logic [SLOT_W-1:0]   ram_rd_bits;
   slot_type            ram_rd_slot;

   // First stage
   logic              req_accept, advance, out_free;
   logic              s1_valid_ff, s1_valid_in;
   op_type            s1_op_ff, s1_op_in;
   status_type        s1_status_ff, s1_status_in;
   logic [TIME_W-1:0] s1_now_ff;

   // Second stage state
   logic              quiet_ff, quiet_in;
   logic [TIME_W-1:0] last_beat_ff, last_beat_in;
   logic [SEQ_W-1:0]  beat_seq_ff, beat_seq_in;
   logic [TIME_W-1:0] elapsed;
   logic              beat_due;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [LEN_W-1:0]     rsp_length_ff, rsp_length_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic                 rsp_quiet_ff;

   assign req_cmd      = cmd_type'(req_tuser[1:0]);
   assign req_extended = req_tuser[2];
   assign req_id       = req_tdata[10:0];
   assign req_length   = req_tdata[14:11];
   assign req_payload  = req_tdata[78:15];
   assign req_now      = req_tdata[110:79];

   assign clamped_length = (req_length > MAX_DLC) ? MAX_DLC : req_length;

   // ---------------------------------------------------------------- handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         command_id_ff <= '0;
         period_ff     <= DEFAULT_PERIOD;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_COMMAND_ID: command_id_ff <= csr_data[ID_W-1:0];
            CSR_PERIOD:     period_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 1
   assign wr_next = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + PtrWidth'(1);
   assign rd_next = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + PtrWidth'(1);

   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      s1_op_in     = OP_DONE;
      s1_status_in = ST_NO_BEAT;
      s1_valid_in  = s1_valid_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
         case (req_cmd)
            CMD_PUSH: begin
               if (req_extended) begin
                  s1_status_in = ST_EXTENDED;
               end else if (wr_next == rd_ptr_ff) begin
                  s1_status_in = ST_FULL;
               end else begin
                  ram_wr_en    = 1'b1;
                  wr_ptr_in    = wr_next;
                  s1_status_in = ST_STORED;
               end
            end
            CMD_POP: begin
               if (rd_ptr_ff == wr_ptr_ff) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  ram_rd_en = 1'b1;
                  rd_ptr_in = rd_next;
                  s1_op_in  = OP_POP;
               end
            end
            CMD_TICK: s1_op_in = OP_TICK;
            default: ;
         endcase
      end
   end

   assign ram_wr_data.id      = req_id;
   assign ram_wr_data.length  = clamped_length;
   assign ram_wr_data.payload = keep_bytes(req_payload, clamped_length);

   canrxf_ram #(
      .DATA_WIDTH(SLOT_W),
      .DEPTH     (RING_DEPTH)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(wr_ptr_ff),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(rd_ptr_ff),
      .rd_data(ram_rd_bits)
   );

   assign ram_rd_slot = slot_type'(ram_rd_bits);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff     <= s1_op_in;
         s1_status_ff <= s1_status_in;
         s1_now_ff    <= req_now;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // The quiet flag lives here, so a tick right behind a silencing pop
   // already sees it.
   assign elapsed  = s1_now_ff - last_beat_ff;
   assign beat_due = !quiet_ff && (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period_ff});

   always_comb begin
      quiet_in       = quiet_ff;
      last_beat_in   = last_beat_ff;
      beat_seq_in    = beat_seq_ff;
      rsp_status_in  = s1_status_ff;
      rsp_id_in      = '0;
      rsp_length_in  = '0;
      rsp_payload_in = '0;
      case (s1_op_ff)
         OP_POP: begin
            rsp_status_in  = ST_POPPED;
            rsp_id_in      = ram_rd_slot.id;
            rsp_length_in  = ram_rd_slot.length;
            rsp_payload_in = ram_rd_slot.payload;
            if (ram_rd_slot.id == command_id_ff) begin
               quiet_in = 1'b1;
            end
         end
         OP_TICK: begin
            if (beat_due) begin
               rsp_status_in  = ST_BEAT;
               rsp_id_in      = BEAT_ID;
               rsp_length_in  = MAX_DLC;
               rsp_payload_in = {{(PAYLOAD_W-24){1'b0}}, beat_seq_ff, BEAT_BYTE1, BEAT_BYTE0};
               last_beat_in   = s1_now_ff;
               beat_seq_in    = beat_seq_ff + SEQ_W'(1);
            end else begin
               rsp_status_in = ST_NO_BEAT;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         quiet_ff     <= 1'b0;
         last_beat_ff <= '0;
         beat_seq_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            quiet_ff     <= quiet_in;
            last_beat_ff <= last_beat_in;
            beat_seq_ff  <= beat_seq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_id_ff      <= rsp_id_in;
         rsp_length_ff  <= rsp_length_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_quiet_ff   <= quiet_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_quiet_ff, rsp_payload_ff, rsp_length_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

[hw/rtl/canrxf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// canrxf_checker: port-level checks for the CAN receive frame FIFO
// Watches the result channel for stalled-result stability and for result
// frames that match their status.
// ----------------------------------------------------------------------------
module canrxf_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [canrxf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [canrxf_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   import canrxf_pkg::*;

   logic [ID_W-1:0]      out_id;
   logic [LEN_W-1:0]     out_length;
   logic [PAYLOAD_W-1:0] out_payload;
   logic                 out_quiet;
   logic                 no_frame;

   assign out_id      = rsp_tdata[10:0];
   assign out_length  = rsp_tdata[14:11];
   assign out_payload = rsp_tdata[78:15];
   assign out_quiet   = rsp_tdata[79];
   assign no_frame    = (rsp_tuser == ST_STORED) || (rsp_tuser == ST_FULL) ||
                        (rsp_tuser == ST_EXTENDED) || (rsp_tuser == ST_EMPTY) ||
                        (rsp_tuser == ST_NO_BEAT);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_beat_not_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_BEAT) |-> !out_quiet)
      else $error("heartbeat sent while quiet");

   a_beat_format: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_BEAT) |->
         (out_id == BEAT_ID) && (out_length == MAX_DLC) &&
         (out_payload[15:0] == {BEAT_BYTE1, BEAT_BYTE0}) && (out_payload[63:24] == '0))
      else $error("malformed heartbeat frame");

   a_no_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && no_frame |-> (out_id == '0) && (out_length == '0) && (out_payload == '0))
      else $error("frame fields set on a result without a frame");

   a_popped_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_POPPED) |-> out_length <= MAX_DLC)
      else $error("popped frame longer than eight bytes");

endmodule

bind can_rx_frame_fifo_with_heartbeat canrxf_checker u_canrxf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the CAN receive frame FIFO with heartbeat
// Requests for push, pop and time tick (and the unused command code) go
// through the request stream with random gaps. A predictor keeps its own copy
// of the ring, the quiet flag, the heartbeat timer and both registers. It
// works out each expected result when the request is accepted. A checker takes
// the result stream with random stalls and compares every field in order.
// ----------------------------------------------------------------------------
module tb_top;
   import canrxf_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int DEPTH = RING_DEPTH_DEFAULT;
   localparam int PTR_W = $clog2(DEPTH);

   typedef struct packed {
      status_type           status;
      logic [ID_W-1:0]      id;
      logic [LEN_W-1:0]     length;
      logic [PAYLOAD_W-1:0] payload;
      logic                 quiet;
   } frame_result_type;

   // Layout of rsp_tdata, highest field first.
   typedef struct packed {
      logic                 quiet;
      logic [PAYLOAD_W-1:0] payload;
      logic [LEN_W-1:0]     length;
      logic [ID_W-1:0]      id;
   } rsp_fields_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Predictor state.
   logic [ID_W-1:0]      slot_id_q   [DEPTH];
   logic [LEN_W-1:0]     slot_len_q  [DEPTH];
   logic [PAYLOAD_W-1:0] slot_data_q [DEPTH];
   logic [PTR_W-1:0]     wr_ptr = '0;
   logic [PTR_W-1:0]     rd_ptr = '0;
   logic                 quiet_q = 1'b0;
   logic [TIME_W-1:0]    last_beat_ms = '0;
   logic [SEQ_W-1:0]     beat_seq = '0;
   logic [ID_W-1:0]      cfg_command_id = '0;
   logic [PERIOD_W-1:0]  cfg_period = DEFAULT_PERIOD;

   frame_result_type pending_frame_results[$];
   int unsigned      mismatch_count = 0;
   int unsigned      request_count = 0;
   bit               req_idle_on = 1'b1;
   bit               rsp_stall_on = 1'b1;
   bit               allow_command_id = 1'b0;

   can_rx_frame_fifo_with_heartbeat u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   function automatic logic [PAYLOAD_W-1:0] low_bytes(logic [PAYLOAD_W-1:0] data,
                                                      logic [LEN_W-1:0] count);
      if (count >= 8) return data;
      return data & ((PAYLOAD_W'(1) << (8 * count)) - 1);
   endfunction

   function automatic bit id_in_ring(logic [ID_W-1:0] id);
      logic [PTR_W-1:0] ptr;
      for (ptr = rd_ptr; ptr != wr_ptr; ptr = ring_next(ptr)) begin
         if (slot_id_q[ptr] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic frame_result_type predict_frame_result(
         logic [1:0] cmd, logic [ID_W-1:0] id, logic ext, logic [LEN_W-1:0] len,
         logic [PAYLOAD_W-1:0] data, logic [TIME_W-1:0] now);
      frame_result_type res;
      logic [LEN_W-1:0]  dlc;
      logic [TIME_W-1:0] elapsed;
      res = '0;
      res.status = ST_NO_BEAT;
      case (cmd)
         CMD_PUSH: begin
            dlc = (len > MAX_DLC) ? MAX_DLC : len;
            if (ext) begin
               res.status = ST_EXTENDED;
            end else if (ring_next(wr_ptr) == rd_ptr) begin
               res.status = ST_FULL;
            end else begin
               slot_id_q[wr_ptr]   = id;
               slot_len_q[wr_ptr]  = dlc;
               slot_data_q[wr_ptr] = low_bytes(data, dlc);
               wr_ptr = ring_next(wr_ptr);
               res.status = ST_STORED;
            end
         end
         CMD_POP: begin
            if (rd_ptr == wr_ptr) begin
               res.status = ST_EMPTY;
            end else begin
               res.id      = slot_id_q[rd_ptr];
               res.length  = slot_len_q[rd_ptr];
               res.payload = low_bytes(slot_data_q[rd_ptr], slot_len_q[rd_ptr]);
               rd_ptr = ring_next(rd_ptr);
               if (res.id == cfg_command_id) quiet_q = 1'b1;
               res.status = ST_POPPED;
            end
         end
         CMD_TICK: begin
            // Elapsed time wraps with the millisecond counter.
            elapsed = now - last_beat_ms;
            if (!quiet_q && elapsed >= TIME_W'(cfg_period)) begin
               last_beat_ms = now;
               res.id      = BEAT_ID;
               res.length  = MAX_DLC;
               res.payload = {40'b0, beat_seq, BEAT_BYTE1, BEAT_BYTE0};
               beat_seq    = beat_seq + 1'b1;
               res.status  = ST_BEAT;
            end
         end
         default: ;
      endcase
      res.quiet = quiet_q;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [PAYLOAD_W-1:0] got,
                                  input logic [PAYLOAD_W-1:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Leaves req_tvalid high after acceptance; the next call either replaces the
   // request in the same step or lowers valid for its gap.
   task automatic send_request(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                               input logic ext, input logic [LEN_W-1:0] len,
                               input logic [PAYLOAD_W-1:0] data,
                               input logic [TIME_W-1:0] now);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({now, data, len, id});
      req_tuser  <= {ext, cmd};
      do @(posedge clock); while (!req_tready);
      pending_frame_results.push_back(predict_frame_result(cmd, id, ext, len, data, now));
      request_count++;
   endtask

   task automatic send_push(input logic [ID_W-1:0] id, input logic ext,
                            input logic [LEN_W-1:0] len, input logic [PAYLOAD_W-1:0] data);
      send_request(CMD_PUSH, id, ext, len, data, $urandom);
   endtask

   task automatic send_pop();
      send_request(CMD_POP, ID_W'($urandom), 1'($urandom), LEN_W'($urandom),
                   {$urandom, $urandom}, $urandom);
   endtask

   task automatic send_tick(input logic [TIME_W-1:0] now);
      send_request(CMD_TICK, ID_W'($urandom), 1'($urandom), LEN_W'($urandom),
                   {$urandom, $urandom}, now);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (pending_frame_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_COMMAND_ID: cfg_command_id = value[ID_W-1:0];
         CSR_PERIOD:     cfg_period = value;
         default: ;
      endcase
   endtask

   function automatic logic [TIME_W-1:0] pick_tick_time();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1, 2, 3: return last_beat_ms + cfg_period + $urandom_range(0, 3);
         4:       return last_beat_ms + cfg_period - 1;
         default: return last_beat_ms + $urandom_range(0, cfg_period);
      endcase
   endfunction

   task automatic send_random_op(input int unsigned push_pct, input int unsigned pop_pct);
      int unsigned          pick;
      logic [1:0]           cmd;
      logic [ID_W-1:0]      id;
      logic [LEN_W-1:0]     len;
      logic [PAYLOAD_W-1:0] data;
      pick = $urandom_range(0, 99);
      // Until the quiet phase, no frame may carry the command ID.
      do id = ID_W'($urandom); while (!allow_command_id && id == cfg_command_id);
      len  = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(9, 15))
                                         : LEN_W'($urandom_range(0, 8));
      data = {$urandom, $urandom};
      if (pick < push_pct) cmd = CMD_PUSH;
      else if (pick < push_pct + pop_pct) cmd = CMD_POP;
      else if (pick < 98) cmd = CMD_TICK;
      else cmd = CMD_UNUSED;
      send_request(cmd, id, $urandom_range(0, 9) == 0, len, data, pick_tick_time());
   endtask

   task automatic test_frame_basics();
      write_register(CSR_COMMAND_ID, CSR_DATA_W'(11'h555));
      send_pop();
      send_push(11'h7FF, 1'b1, 4'hF, '1);
      send_push(11'h000, 1'b0, 4'd0, '1);
      send_push(11'h7FF, 1'b0, 4'd8, '1);
      send_push(11'h2AA, 1'b0, 4'hF, 64'h0123_4567_89AB_CDEF);
      send_push(11'h155, 1'b0, 4'd3, '1);
      repeat (4) send_pop();
      send_pop();
      send_request(CMD_UNUSED, '1, 1'b1, '1, '1, '1);
   endtask

   task automatic test_heartbeat_timing();
      send_tick(32'd1999);
      send_tick(32'd2000);
      send_tick(32'd3999);
      send_tick(32'd4000);
      send_tick(32'hFFFF_FFFF);
      // Elapsed time across the counter wrap.
      send_tick(32'd1998);
      send_tick(32'd1999);
      write_register(CSR_PERIOD, 16'd0);
      send_tick(32'd1999);
      send_tick(32'd0);
      write_register(CSR_PERIOD, 16'hFFFF);
      send_tick(32'd65534);
      send_tick(32'd65535);
      write_register(CSR_PERIOD, 16'd1);
      send_tick(32'd65535);
      send_tick(32'd65536);
   endtask

   // Enough heartbeats for the sequence byte to wrap around.
   task automatic test_sequence_wrap();
      logic [TIME_W-1:0] now;
      now = $urandom;
      for (int i = 0; i < 340; i++) begin
         if (i % 40 == 0) req_idle_on = $urandom_range(0, 2) != 0;
         now = now + (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3));
         send_tick(now);
      end
   endtask

   task automatic test_random_traffic();
      int unsigned      chunk;
      int unsigned      kind;
      int unsigned      len;
      logic [ID_W-1:0]  new_id;
      chunk = 0;
      while (request_count < 1000) begin
         if (chunk < 2 || $urandom_range(0, 2) == 0) begin
            case (chunk)
               0:       new_id = 11'h000;
               1:       new_id = 11'h7FF;
               default: new_id = ID_W'($urandom);
            endcase
            if (!id_in_ring(new_id)) write_register(CSR_COMMAND_ID, CSR_DATA_W'(new_id));
            case (chunk < 2 ? chunk : $urandom_range(0, 5))
               0:       write_register(CSR_PERIOD, 16'd0);
               1:       write_register(CSR_PERIOD, 16'hFFFF);
               2:       write_register(CSR_PERIOD, 16'd1);
               3:       write_register(CSR_PERIOD, DEFAULT_PERIOD);
               4:       write_register(CSR_PERIOD, CSR_DATA_W'($urandom_range(0, 50)));
               default: write_register(CSR_PERIOD, CSR_DATA_W'($urandom));
            endcase
         end
         req_idle_on  = $urandom_range(0, 3) != 0;
         rsp_stall_on = $urandom_range(0, 3) != 0;
         kind = $urandom_range(0, 3);
         len  = $urandom_range(20, 45);
         for (int i = 0; i < len; i++) begin
            case (kind)
               0: send_random_op(40, 35);
               1: send_random_op(80, 10);
               2: send_random_op(15, 75);
               default: send_random_op(20, 20);
            endcase
         end
         chunk++;
      end
   endtask

   task automatic test_quiet_mode();
      req_idle_on  = 1'b1;
      rsp_stall_on = 1'b1;
      while (wr_ptr != rd_ptr) send_pop();
      write_register(CSR_COMMAND_ID, CSR_DATA_W'(11'h7FF));
      write_register(CSR_PERIOD, DEFAULT_PERIOD);
      send_push(11'h7FF, 1'b0, 4'd8, {$urandom, $urandom});
      send_push(11'h7FF, 1'b1, 4'd2, {$urandom, $urandom});
      send_push(11'h123, 1'b0, 4'd5, {$urandom, $urandom});
      send_tick(last_beat_ms + DEFAULT_PERIOD);
      send_pop();
      send_tick(last_beat_ms + 32'd5000);
      send_pop();
      send_pop();
      allow_command_id = 1'b1;
      for (int i = 0; i < 120; i++) send_random_op(40, 35);
   endtask

   // Result side: random stalls, then checks each result against the oldest
   // expectation.
   initial begin
      int unsigned      stall;
      frame_result_type want;
      rsp_fields_type   got;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_stall_on ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got = rsp_tdata;
         if (pending_frame_results.size() == 0) begin
            report_mismatch("result with nothing pending, status", PAYLOAD_W'(rsp_tuser),
                            '0);
         end else begin
            want = pending_frame_results.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", PAYLOAD_W'(rsp_tuser), PAYLOAD_W'(want.status));
            if (got.id !== want.id)
               report_mismatch("out_id", PAYLOAD_W'(got.id), PAYLOAD_W'(want.id));
            if (got.length !== want.length)
               report_mismatch("out_length", PAYLOAD_W'(got.length), PAYLOAD_W'(want.length));
            if (got.payload !== want.payload)
               report_mismatch("out_payload", got.payload, want.payload);
            if (got.quiet !== want.quiet)
               report_mismatch("quiet", PAYLOAD_W'(got.quiet), PAYLOAD_W'(want.quiet));
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_frame_basics();
      test_heartbeat_timing();
      test_sequence_wrap();
      test_random_traffic();
      test_quiet_mode();
      wait_until_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
